### sv/mqes_pkg.sv
// shared types and constants of the multi quadrature encoder scanner
// no dependencies; imported by every module of the block
package mqes_pkg;

    localparam int ENCODER_COUNT = 11;
    localparam int IDX_W         = 4;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENCODER_COUNT - 1);

    localparam int POS_W       = 32;
    localparam int ACC_W       = 8;
    localparam int SENS_W      = 7;
    localparam int HIST_W      = 8;
    localparam int BTN_COUNT   = 10;
    localparam int PHASE_W     = 2;
    localparam int BYTE_W      = 8;
    localparam int EXP_W       = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int DIV_CNT_W   = 3;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST_CNT = DIV_CNT_W'(ACC_W - 1);

    localparam logic [SENS_W-1:0]     SENS_RESET  = 7'd4;
    localparam logic [CFG_DATA_W-1:0] TABLE_RESET = 32'h3443_C11C;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SENSITIVITY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_TABLE  = 2'd1;

    // request codes
    localparam logic REQ_CAPTURE = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    // expander codes
    localparam logic [EXP_W-1:0] EXP_FIRST  = 2'd0;
    localparam logic [EXP_W-1:0] EXP_SECOND = 2'd1;
    localparam logic [EXP_W-1:0] EXP_THIRD  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DIV,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic             capture;
        logic             look;
        logic             div_step;
        logic             update;
        logic [IDX_W-1:0] idx;
    } ctrl_cmd_t;

    typedef struct packed {
        logic go_div;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

### sv/mqes_ctrl.sv
// sequencer of the encoder scanner: input handshake and per-encoder steps
// depends on mqes_pkg
module mqes_ctrl
    import mqes_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_req_type,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                if (s_valid && (s_req_type == REQ_TICK)) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                state_next = status.go_div ? ST_DIV : ST_UPDATE;
            end
            ST_DIV: begin
                if (status.div_last) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (status.out_free) begin
                    if (idx_reg == LAST_IDX) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_LOOK;
                        idx_next   = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd.capture  = 1'b0;
        cmd.look     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.update   = 1'b0;
        cmd.idx      = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid && (s_req_type == REQ_CAPTURE);
            end
            ST_LOOK: begin
                cmd.look = 1'b1;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_UPDATE: begin
                cmd.update = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_div_runs_to_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && !status.div_last) |=> (state_reg == ST_DIV))
        else $error("divider left before its last step");

    a_scan_ends_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE && status.out_free && idx_reg == LAST_IDX)
        |=> (state_reg == ST_IDLE))
        else $error("scan did not end after the last encoder");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (idx_reg <= LAST_IDX))
        else $error("encoder index out of range");
`endif

endmodule

### sv/mqes_dp.sv
// datapath of the encoder scanner: config registers, encoder state,
// delta lookup, shift-subtract divider and result register; depends on mqes_pkg
module mqes_dp
    import mqes_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic [EXP_W-1:0]              s_expander,
    input  logic [BYTE_W-1:0]             s_port_a,
    input  logic [BYTE_W-1:0]             s_port_b,
    input  ctrl_cmd_t                     cmd,
    output dp_status_t                    status,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [IDX_W-1:0]              m_encoder_index,
    output logic signed [POS_W-1:0]       m_position,
    output logic [HIST_W-1:0]             m_button_history,
    output logic [BTN_COUNT-1:0]          m_discrete_buttons,
    output logic                          m_last_of_run
);

    logic [SENS_W-1:0]     sens_reg;
    logic [CFG_DATA_W-1:0] table_reg;

    logic [PHASE_W-1:0] raw_phase_reg   [ENCODER_COUNT];
    logic               raw_press_reg   [ENCODER_COUNT];
    logic [PHASE_W-1:0] prior_phase_reg [ENCODER_COUNT];
    logic [ACC_W-1:0]   step_sum_reg    [ENCODER_COUNT];
    logic [POS_W-1:0]   position_reg    [ENCODER_COUNT];
    logic [HIST_W-1:0]  history_reg     [ENCODER_COUNT];
    logic [BTN_COUNT-1:0] buttons_reg;

    logic                 acc_neg_reg;
    logic                 move_reg;
    logic [ACC_W-1:0]     rem_reg, rem_next;
    logic [ACC_W-1:0]     quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic                 m_valid_reg;
    logic [IDX_W-1:0]     m_index_reg;
    logic [POS_W-1:0]     m_position_reg;
    logic [HIST_W-1:0]    m_history_reg;
    logic [BTN_COUNT-1:0] m_buttons_reg;
    logic                 m_last_reg;

    // lookup for the encoder under scan
    logic [PHASE_W-1:0]   old_phase, new_phase;
    logic [1:0]           delta;
    logic                 move;
    logic [SENS_W-1:0]    sens_eff;
    logic signed [ACC_W:0] acc;
    logic [ACC_W:0]       acc_mag;
    logic [ACC_W-1:0]     mag;
    logic                 big;
    logic [ACC_W:0]       trial;
    logic [ACC_W:0]       quo_signed;
    logic [ACC_W-1:0]     rem_signed;

    assign old_phase = prior_phase_reg[cmd.idx];
    assign new_phase = raw_phase_reg[cmd.idx];
    assign delta     = table_reg[{old_phase, new_phase, 1'b0} +: 2];
    assign move      = (delta != 2'b00) && (old_phase != new_phase);
    assign sens_eff  = (sens_reg == '0) ? SENS_W'(1) : sens_reg;
    assign acc       = $signed({step_sum_reg[cmd.idx][ACC_W-1], step_sum_reg[cmd.idx]})
                     + $signed({{(ACC_W-1){delta[1]}}, delta});
    assign acc_mag   = acc[ACC_W] ? (ACC_W+1)'(-acc) : acc;
    assign mag       = acc_mag[ACC_W-1:0];
    assign big       = mag >= {1'b0, sens_eff};

    // one quotient bit per step
    assign trial = {rem_reg, quo_reg[ACC_W-1]};
    always_comb begin
        if (trial >= {2'b00, sens_eff}) begin
            rem_next = ACC_W'(trial - {2'b00, sens_eff});
            quo_next = {quo_reg[ACC_W-2:0], 1'b1};
        end else begin
            rem_next = trial[ACC_W-1:0];
            quo_next = {quo_reg[ACC_W-2:0], 1'b0};
        end
    end

    assign quo_signed = acc_neg_reg ? (ACC_W+1)'(-{1'b0, quo_reg}) : {1'b0, quo_reg};
    assign rem_signed = acc_neg_reg ? ACC_W'(-rem_reg) : rem_reg;

    assign status.go_div   = move && big;
    assign status.div_last = (div_cnt_reg == DIV_LAST_CNT);
    assign status.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_reg  <= SENS_RESET;
            table_reg <= TABLE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SENSITIVITY: sens_reg  <= cfg_data[SENS_W-1:0];
                CFG_STEP_TABLE:  table_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // capture unpacking, push bits active low
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENCODER_COUNT; i++) begin
                raw_phase_reg[i] <= '0;
                raw_press_reg[i] <= 1'b0;
            end
            buttons_reg <= '0;
        end else if (cmd.capture) begin
            unique case (s_expander)
                EXP_FIRST: begin
                    raw_phase_reg[0] <= s_port_b[1:0];
                    raw_phase_reg[1] <= s_port_b[4:3];
                    raw_phase_reg[2] <= s_port_b[7:6];
                    raw_phase_reg[3] <= s_port_a[2:1];
                    raw_press_reg[0] <= !s_port_b[2];
                    raw_press_reg[1] <= !s_port_b[5];
                    raw_press_reg[2] <= !s_port_a[0];
                    raw_press_reg[3] <= !s_port_a[3];
                end
                EXP_SECOND: begin
                    raw_phase_reg[4] <= s_port_b[1:0];
                    raw_phase_reg[5] <= s_port_b[7:6];
                    raw_phase_reg[6] <= s_port_a[5:4];
                    raw_press_reg[4] <= !s_port_b[2];
                    raw_press_reg[5] <= !s_port_a[0];
                    raw_press_reg[6] <= !s_port_a[6];
                    buttons_reg[2:0] <= ~s_port_b[5:3];
                    buttons_reg[5:3] <= ~s_port_a[3:1];
                end
                EXP_THIRD: begin
                    raw_phase_reg[7]  <= s_port_b[1:0];
                    raw_phase_reg[8]  <= s_port_b[4:3];
                    raw_phase_reg[9]  <= s_port_b[7:6];
                    raw_phase_reg[10] <= s_port_a[2:1];
                    raw_press_reg[7]  <= !s_port_b[2];
                    raw_press_reg[8]  <= !s_port_b[5];
                    raw_press_reg[9]  <= !s_port_a[0];
                    raw_press_reg[10] <= !s_port_a[3];
                    buttons_reg[9:6]  <= ~s_port_a[7:4];
                end
                default: begin
                end
            endcase
        end
    end

    // per-encoder scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENCODER_COUNT; i++) begin
                prior_phase_reg[i] <= '0;
                step_sum_reg[i]    <= '0;
                position_reg[i]    <= '0;
                history_reg[i]     <= '0;
            end
        end else if (cmd.update) begin
            prior_phase_reg[cmd.idx] <= new_phase;
            history_reg[cmd.idx] <= {history_reg[cmd.idx][HIST_W-2:0], raw_press_reg[cmd.idx]};
            if (move_reg) begin
                position_reg[cmd.idx] <= position_reg[cmd.idx]
                                       + {{(POS_W-ACC_W-1){quo_signed[ACC_W]}}, quo_signed};
                step_sum_reg[cmd.idx] <= rem_signed;
            end
        end
    end

    // divider registers; below threshold the quotient is zero and all stays in rem
    always_ff @(posedge aclk) begin
        if (cmd.look) begin
            acc_neg_reg <= acc[ACC_W];
            move_reg    <= move;
            div_cnt_reg <= '0;
            if (big) begin
                rem_reg <= '0;
                quo_reg <= mag;
            end else begin
                rem_reg <= mag;
                quo_reg <= '0;
            end
        end else if (cmd.div_step) begin
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.update) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            m_index_reg    <= cmd.idx;
            m_position_reg <= move_reg
                ? position_reg[cmd.idx] + {{(POS_W-ACC_W-1){quo_signed[ACC_W]}}, quo_signed}
                : position_reg[cmd.idx];
            m_history_reg  <= {history_reg[cmd.idx][HIST_W-2:0], raw_press_reg[cmd.idx]};
            m_buttons_reg  <= buttons_reg;
            m_last_reg     <= (cmd.idx == LAST_IDX);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_encoder_index    = m_index_reg;
    assign m_position         = $signed(m_position_reg);
    assign m_button_history   = m_history_reg;
    assign m_discrete_buttons = m_buttons_reg;
    assign m_last_of_run      = m_last_reg;

`ifndef NO_ASSERTIONS
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while full");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_last_reg == (m_index_reg == LAST_IDX)))
        else $error("last flag does not match encoder index");

    a_rem_below_sens: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |=> (rem_reg < {1'b0, sens_eff}))
        else $error("divider remainder not below divisor");
`endif

endmodule

### sv/multi_quadrature_encoder_scanner.sv
// top level of the multi quadrature encoder scanner
// depends on mqes_pkg, mqes_ctrl and mqes_dp

// A capture word (req_type 0) unpacks one expander's two port bytes into
// encoder phases, push bits and button flags; it gives no result. A tick
// word (req_type 1) scans encoders 0 to 10 in order and gives one result
// word per encoder, the last one flagged by last_of_run. Each encoder runs
// a lookup, then a writeback into the result register, with the
// shift-subtract divider between them when its accumulator reaches the
// sensitivity; the writeback waits while m_ready holds the single result
// register full. s_ready is low while a scan runs. The configuration port
// is always ready; write it only while no scan is running. No clearing
// pass follows reset.
module multi_quadrature_encoder_scanner
    import mqes_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // input words
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_req_type,
    input  logic [EXP_W-1:0]        s_expander,
    input  logic [BYTE_W-1:0]       s_port_a,
    input  logic [BYTE_W-1:0]       s_port_b,
    // result words
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [IDX_W-1:0]        m_encoder_index,
    output logic signed [POS_W-1:0] m_position,
    output logic [HIST_W-1:0]       m_button_history,
    output logic [BTN_COUNT-1:0]    m_discrete_buttons,
    output logic                    m_last_of_run,
    // register writes: 0 sensitivity, 1 step table, others ignored
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    // sequencer: owns the input handshake and the encoder index
    mqes_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // datapath: encoder state, divider and result register
    mqes_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_expander         (s_expander),
        .s_port_a           (s_port_a),
        .s_port_b           (s_port_b),
        .cmd                (cmd),
        .status             (status),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_encoder_index    (m_encoder_index),
        .m_position         (m_position),
        .m_button_history   (m_button_history),
        .m_discrete_buttons (m_discrete_buttons),
        .m_last_of_run      (m_last_of_run)
    );

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// testbench of multi_quadrature_encoder_scanner: a shadow model predicts every report word
// depends on mqes_pkg and the scanner rtl; needs nothing else

module tb;
    import mqes_pkg::*;

    // one input word as it crosses the s_ channel
    typedef struct packed {
        logic              req;
        logic [EXP_W-1:0]  expander;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
    } in_word_t;

    // one report word as it crosses the m_ channel
    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [POS_W-1:0] pos;
        logic [HIST_W-1:0]       hist;
        logic [BTN_COUNT-1:0]    btns;
        logic                    last;
    } enc_report_t;

    // every input of the block starts at a known value
    logic                    aclk               = 1'b0;
    logic                    aresetn            = 1'b0;
    logic                    s_valid            = 1'b0;
    logic                    s_ready;
    logic                    s_req_type         = REQ_CAPTURE;
    logic [EXP_W-1:0]        s_expander         = EXP_FIRST;
    logic [BYTE_W-1:0]       s_port_a           = '0;
    logic [BYTE_W-1:0]       s_port_b           = '0;
    logic                    m_valid;
    logic                    m_ready            = 1'b0;
    logic [IDX_W-1:0]        m_encoder_index;
    logic signed [POS_W-1:0] m_position;
    logic [HIST_W-1:0]       m_button_history;
    logic [BTN_COUNT-1:0]    m_discrete_buttons;
    logic                    m_last_of_run;
    logic                    cfg_valid          = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index          = CFG_SENSITIVITY;
    logic [CFG_DATA_W-1:0]   cfg_data           = '0;

    multi_quadrature_encoder_scanner dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_req_type         (s_req_type),
        .s_expander         (s_expander),
        .s_port_a           (s_port_a),
        .s_port_b           (s_port_b),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_encoder_index    (m_encoder_index),
        .m_position         (m_position),
        .m_button_history   (m_button_history),
        .m_discrete_buttons (m_discrete_buttons),
        .m_last_of_run      (m_last_of_run),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // 12 ns clock
    initial begin
        forever #6 aclk = ~aclk;
    end

    // shadow copy of the block's registers and encoder state
    logic [SENS_W-1:0]     cur_sens;
    logic [CFG_DATA_W-1:0] cur_table;
    logic [PHASE_W-1:0]    seen_phase [ENCODER_COUNT];
    logic                  seen_push  [ENCODER_COUNT];
    logic [PHASE_W-1:0]    last_phase [ENCODER_COUNT];
    logic [ACC_W-1:0]      step_acc   [ENCODER_COUNT];
    logic [POS_W-1:0]      pos_count  [ENCODER_COUNT];
    logic [HIST_W-1:0]     push_log   [ENCODER_COUNT];
    logic [BTN_COUNT-1:0]  btn_state;

    // words waiting to be sent and report words waiting to arrive
    in_word_t    outgoing_words[$];
    enc_report_t pending_reports[$];
    int          words_queued = 0;
    int          words_done   = 0;
    int          mismatches   = 0;

    // the physical knobs and buttons that stimulus turns and presses
    int knob_step [ENCODER_COUNT];
    bit knob_down [ENCODER_COUNT];
    bit knob_btn  [BTN_COUNT];

    // port bit low means pushed
    task automatic latch_encoder(input int n, input logic [PHASE_W-1:0] ph, input logic port_bit);
        seen_phase[n] = ph;
        seen_push[n]  = ~port_bit;
    endtask

    // apply one accepted word to the shadow state; a tick queues eleven reports
    task automatic absorb_word(input in_word_t w);
        int                 n;
        int                 sens;
        int                 acc;
        int                 delta;
        logic [1:0]         entry;
        logic [PHASE_W-1:0] old_ph;
        logic [PHASE_W-1:0] new_ph;
        enc_report_t        rep;
        if (w.req == REQ_CAPTURE) begin
            case (w.expander)
                EXP_FIRST: begin
                    latch_encoder(0, w.b[1:0], w.b[2]);
                    latch_encoder(1, w.b[4:3], w.b[5]);
                    latch_encoder(2, w.b[7:6], w.a[0]);
                    latch_encoder(3, w.a[2:1], w.a[3]);
                end
                EXP_SECOND: begin
                    latch_encoder(4, w.b[1:0], w.b[2]);
                    latch_encoder(5, w.b[7:6], w.a[0]);
                    latch_encoder(6, w.a[5:4], w.a[6]);
                    for (n = 0; n < 3; n++) begin
                        btn_state[n]     = ~w.b[3 + n];
                        btn_state[3 + n] = ~w.a[1 + n];
                    end
                end
                EXP_THIRD: begin
                    latch_encoder(7, w.b[1:0], w.b[2]);
                    latch_encoder(8, w.b[4:3], w.b[5]);
                    latch_encoder(9, w.b[7:6], w.a[0]);
                    latch_encoder(10, w.a[2:1], w.a[3]);
                    for (n = 0; n < 4; n++)
                        btn_state[6 + n] = ~w.a[4 + n];
                end
                default: ; // unknown expander leaves everything alone
            endcase
        end else begin
            // zero sensitivity behaves as one
            sens = (cur_sens == 0) ? 1 : int'(cur_sens);
            for (n = 0; n < ENCODER_COUNT; n++) begin
                old_ph = last_phase[n];
                new_ph = seen_phase[n];
                entry  = cur_table[2 * (4 * int'(old_ph) + int'(new_ph)) +: 2];
                delta  = entry[1] ? int'(entry) - 4 : int'(entry);
                // diagonal entries and zero deltas leave the accumulator alone
                if (delta != 0 && old_ph != new_ph) begin
                    acc = int'($signed(step_acc[n])) + delta;
                    if ((acc < 0 ? -acc : acc) >= sens) begin
                        pos_count[n] = pos_count[n] + POS_W'(acc / sens);
                        acc = acc % sens;
                    end
                    step_acc[n] = acc[ACC_W-1:0];
                end
                last_phase[n] = new_ph;
                push_log[n]   = {push_log[n][HIST_W-2:0], seen_push[n]};
                rep.idx  = IDX_W'(n);
                rep.pos  = pos_count[n];
                rep.hist = push_log[n];
                rep.btns = btn_state;
                rep.last = (n == ENCODER_COUNT - 1);
                pending_reports.push_back(rep);
            end
        end
    endtask

    // quadrature order 0, 1, 3, 2
    function automatic logic [PHASE_W-1:0] phase_of_step(input int k);
        logic [1:0] g;
        g = k[1:0];
        return g ^ (g >> 1);
    endfunction

    // port bytes that one expander would read from the knobs; unmapped bits random
    function automatic in_word_t capture_word(input logic [EXP_W-1:0] expander);
        in_word_t w;
        int       base;
        int       n;
        w.req      = REQ_CAPTURE;
        w.expander = expander;
        w.a        = BYTE_W'($urandom);
        w.b        = BYTE_W'($urandom);
        if (expander == EXP_SECOND) begin
            w.b[1:0] = phase_of_step(knob_step[4]);
            w.b[2]   = ~knob_down[4];
            w.b[7:6] = phase_of_step(knob_step[5]);
            w.a[0]   = ~knob_down[5];
            w.a[5:4] = phase_of_step(knob_step[6]);
            w.a[6]   = ~knob_down[6];
            for (n = 0; n < 3; n++) begin
                w.b[3 + n] = ~knob_btn[n];
                w.a[1 + n] = ~knob_btn[3 + n];
            end
        end else begin
            base     = (expander == EXP_FIRST) ? 0 : 7;
            w.b[1:0] = phase_of_step(knob_step[base]);
            w.b[2]   = ~knob_down[base];
            w.b[4:3] = phase_of_step(knob_step[base + 1]);
            w.b[5]   = ~knob_down[base + 1];
            w.b[7:6] = phase_of_step(knob_step[base + 2]);
            w.a[0]   = ~knob_down[base + 2];
            w.a[2:1] = phase_of_step(knob_step[base + 3]);
            w.a[3]   = ~knob_down[base + 3];
            if (expander == EXP_THIRD) begin
                for (n = 0; n < 4; n++)
                    w.a[4 + n] = ~knob_btn[6 + n];
            end
        end
        return w;
    endfunction

    task automatic queue_word(input in_word_t w);
        outgoing_words.push_back(w);
        words_queued++;
    endtask

    // tick payload is don't-care, so it carries noise
    task automatic queue_tick();
        queue_word('{req: REQ_TICK, expander: EXP_W'($urandom), a: BYTE_W'($urandom),
                     b: BYTE_W'($urandom)});
    endtask

    task automatic queue_all_captures();
        queue_word(capture_word(EXP_FIRST));
        queue_word(capture_word(EXP_SECOND));
        queue_word(capture_word(EXP_THIRD));
    endtask

    // one polling round: move the knobs, read the expanders, tick
    task automatic queue_round();
        int n;
        int first;
        for (n = 0; n < ENCODER_COUNT; n++) begin
            case ($urandom_range(0, 7))
                3, 4:    knob_step[n] = knob_step[n] + 1;
                5, 6:    knob_step[n] = knob_step[n] - 1;
                7:       knob_step[n] = knob_step[n] + 2; // skipped state
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
                knob_down[n] = !knob_down[n];
        end
        for (n = 0; n < BTN_COUNT; n++) begin
            if ($urandom_range(0, 3) == 0)
                knob_btn[n] = !knob_btn[n];
        end
        // expanders in rotated order from a random first one, now and then one is missed
        first = $urandom_range(0, 2);
        for (n = 0; n < 3; n++) begin
            if ($urandom_range(0, 7) != 0)
                queue_word(capture_word(EXP_W'((first + n) % 3)));
        end
        // garbage capture, sometimes from the unknown expander
        if ($urandom_range(0, 5) == 0)
            queue_word('{req: REQ_CAPTURE, expander: EXP_W'($urandom_range(0, 3)),
                         a: BYTE_W'($urandom), b: BYTE_W'($urandom)});
        queue_tick();
        if ($urandom_range(0, 7) == 0)
            queue_tick();
    endtask

    // register write; the shadow copy follows at the accepting edge
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_SENSITIVITY)
            cur_sens = val[SENS_W-1:0];
        else if (idx == CFG_STEP_TABLE)
            cur_table = val;
    endtask

    // wait until every word is taken and every report is in, then let the block drain
    task automatic settle();
        @(posedge aclk);
        while (words_done != words_queued || pending_reports.size() != 0)
            @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic run_phase(input int words);
        int target;
        target = words_queued + words;
        while (words_queued < target)
            queue_round();
        settle();
    endtask

    // driver: one word at a time, random gap after each accepted word
    int send_gap   = 0;
    bit send_burst = 1'b0;

    always @(posedge aclk) begin : driver
        in_word_t nxt;
        bit       slot_free;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            slot_free = !s_valid;
            if (s_valid && s_ready) begin
                absorb_word('{req: s_req_type, expander: s_expander, a: s_port_a, b: s_port_b});
                words_done++;
                slot_free = 1'b1;
                // now and then switch between gapped traffic and back-to-back
                if ($urandom_range(0, 31) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 15);
            end
            if (slot_free) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (outgoing_words.size() != 0) begin
                    nxt = outgoing_words.pop_front();
                    s_req_type <= nxt.req;
                    s_expander <= nxt.expander;
                    s_port_a   <= nxt.a;
                    s_port_b   <= nxt.b;
                    s_valid    <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random stall after each report word, compare against the oldest expectation
    int recv_wait  = 0;
    bit recv_burst = 1'b0;

    always @(posedge aclk) begin : monitor
        enc_report_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_reports.size() == 0) begin
                    $error("unexpected report word for encoder %0d", m_encoder_index);
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    if (m_encoder_index !== want.idx) begin
                        $error("encoder_index: expected %0d, got %0d", want.idx, m_encoder_index);
                        mismatches++;
                    end
                    if (m_position !== want.pos) begin
                        $error("position: expected %0d, got %0d", want.pos, m_position);
                        mismatches++;
                    end
                    if (m_button_history !== want.hist) begin
                        $error("button_history: expected %h, got %h", want.hist,
                               m_button_history);
                        mismatches++;
                    end
                    if (m_discrete_buttons !== want.btns) begin
                        $error("discrete_buttons: expected %h, got %h", want.btns,
                               m_discrete_buttons);
                        mismatches++;
                    end
                    if (m_last_of_run !== want.last) begin
                        $error("last_of_run: expected %0d, got %0d", want.last, m_last_of_run);
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 31) == 0)
                    recv_burst = !recv_burst;
                recv_wait = recv_burst ? 0 : $urandom_range(0, 15);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int n;
        int k;
        cur_sens  = SENS_RESET;
        cur_table = TABLE_RESET;
        btn_state = '0;
        for (n = 0; n < ENCODER_COUNT; n++) begin
            seen_phase[n] = '0;
            seen_push[n]  = 1'b0;
            last_phase[n] = '0;
            step_acc[n]   = '0;
            pos_count[n]  = '0;
            push_log[n]   = '0;
            knob_step[n]  = 0;
            knob_down[n]  = 1'b1;
        end
        for (n = 0; n < BTN_COUNT; n++)
            knob_btn[n] = 1'b1;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part at reset settings
        // tick straight out of reset
        queue_tick();
        // all port bits high: phases 3, nothing pushed, buttons released
        queue_word('{req: REQ_CAPTURE, expander: EXP_FIRST, a: 8'hFF, b: 8'hFF});
        queue_word('{req: REQ_CAPTURE, expander: EXP_SECOND, a: 8'hFF, b: 8'hFF});
        queue_word('{req: REQ_CAPTURE, expander: EXP_THIRD, a: 8'hFF, b: 8'hFF});
        queue_tick();
        // all port bits low: phases 0, everything pushed
        queue_word('{req: REQ_CAPTURE, expander: EXP_FIRST, a: 8'h00, b: 8'h00});
        queue_word('{req: REQ_CAPTURE, expander: EXP_SECOND, a: 8'h00, b: 8'h00});
        queue_word('{req: REQ_CAPTURE, expander: EXP_THIRD, a: 8'h00, b: 8'h00});
        queue_tick();
        // unknown expander must change nothing
        queue_word('{req: REQ_CAPTURE, expander: 2'd3, a: 8'hFF, b: 8'hFF});
        queue_tick();
        // one full quadrature cycle, even encoders forward and odd ones back;
        // the first steps stay below the threshold of four
        for (k = 0; k < 4; k++) begin
            for (n = 0; n < ENCODER_COUNT; n++)
                knob_step[n] = knob_step[n] + ((n % 2 == 0) ? 1 : -1);
            queue_all_captures();
            queue_tick();
        end
        settle();

        // random rounds at reset settings
        run_phase(35);

        // writes to unused indexes are dropped
        write_reg(2'd2, $urandom);
        write_reg(2'd3, $urandom);
        // finest step, every delta -1 (diagonal ones too, which must not count)
        write_reg(CFG_SENSITIVITY, 32'd1);
        write_reg(CFG_STEP_TABLE, 32'hFFFF_FFFF);
        run_phase(25);

        // zero sensitivity acts as one, every delta +1
        write_reg(CFG_SENSITIVITY, 32'd0);
        write_reg(CFG_STEP_TABLE, 32'h5555_5555);
        run_phase(20);

        // coarsest nominal step, random table
        write_reg(CFG_SENSITIVITY, 32'd64);
        write_reg(CFG_STEP_TABLE, $urandom);
        run_phase(20);

        // widest sensitivity and an all-zero table
        write_reg(CFG_SENSITIVITY, 32'd127);
        write_reg(CFG_STEP_TABLE, 32'h0000_0000);
        run_phase(15);

        write_reg(CFG_SENSITIVITY, CFG_DATA_W'($urandom_range(1, 64)));
        write_reg(CFG_STEP_TABLE, $urandom);
        run_phase(25);

        // back to the standard table with a small random sensitivity
        write_reg(CFG_SENSITIVITY, CFG_DATA_W'($urandom_range(2, 8)));
        write_reg(CFG_STEP_TABLE, TABLE_RESET);
        run_phase(25);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin : watchdog
        #(5_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule

### files.f
sv/mqes_pkg.sv
sv/mqes_ctrl.sv
sv/mqes_dp.sv
sv/multi_quadrature_encoder_scanner.sv
bench/tb.sv
